// File: sv/grsr_pkg.sv
// ----------------------------------------------------------------------------
// grsr_pkg
// Shared types, constants and the blend function of the glyph row rasterizer.
// ----------------------------------------------------------------------------
package grsr_pkg;

  localparam int ROW_W    = 7;
  localparam int COLOR_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = COLOR_W / CHAN_W;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 3;
  localparam int QCNT_W   = 2;

  localparam logic [COLOR_W-1:0] FG_RESET    = 24'h000000;
  localparam logic [COLOR_W-1:0] BG_RESET    = 24'h333399;
  // blend of the reset colors, floor((fg + 9*bg) / 10) per channel
  localparam logic [COLOR_W-1:0] BLEND_RESET = 24'h2D2D89;

  // x / 10 == (x * 6554) >> 16 for every x up to 2550
  localparam logic [12:0] BLEND_RECIP = 13'd6554;
  localparam int          BLEND_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR      = 2'd0,
    CFG_BG_COLOR      = 2'd1,
    CFG_SMOOTHING_ON  = 2'd2,
    CFG_BACKGROUND_ON = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] blend;
    logic               smooth_on;
    logic               bg_on;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0][COLOR_W-1:0] pix;   // pix[c] is column c
    logic [ROW_W-1:0]              mask;  // bit 6 is column 0
    logic                          done_last;
  } result_t;

  function automatic logic [COLOR_W-1:0] blend_color(input logic [COLOR_W-1:0] fg,
                                                     input logic [COLOR_W-1:0] bg);
    logic [11:0]        sum;
    logic [24:0]        prod;
    logic [CHAN_W-1:0]  f;
    logic [CHAN_W-1:0]  b;
    logic [COLOR_W-1:0] res;
    res = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      f    = fg[i*CHAN_W +: CHAN_W];
      b    = bg[i*CHAN_W +: CHAN_W];
      sum  = {4'b0, f} + {1'b0, b, 3'b0} + {4'b0, b};
      prod = 25'(sum) * 25'(BLEND_RECIP);
      res[i*CHAN_W +: CHAN_W] = prod[BLEND_SHIFT +: CHAN_W];
    end
    return res;
  endfunction

endpackage

// File: sv/grsr_cfg.sv
// ----------------------------------------------------------------------------
// grsr_cfg
// Configuration registers and the precomputed blend color.
// ----------------------------------------------------------------------------
module grsr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [grsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [grsr_pkg::COLOR_W-1:0]      cfg_wdata_i,
  output grsr_pkg::cfg_t                    cfg_o
);

  logic [grsr_pkg::COLOR_W-1:0] fg_q, fg_d;
  logic [grsr_pkg::COLOR_W-1:0] bg_q, bg_d;
  logic [grsr_pkg::COLOR_W-1:0] blend_q, blend_d;
  logic                         smooth_q, smooth_d;
  logic                         bgon_q, bgon_d;

  always_comb begin
    fg_d     = fg_q;
    bg_d     = bg_q;
    smooth_d = smooth_q;
    bgon_d   = bgon_q;
    if (cfg_we_i) begin
      case (grsr_pkg::cfg_idx_e'(cfg_idx_i))
        grsr_pkg::CFG_FG_COLOR:      fg_d     = cfg_wdata_i;
        grsr_pkg::CFG_BG_COLOR:      bg_d     = cfg_wdata_i;
        grsr_pkg::CFG_SMOOTHING_ON:  smooth_d = cfg_wdata_i[0];
        grsr_pkg::CFG_BACKGROUND_ON: bgon_d   = cfg_wdata_i[0];
        default: ;
      endcase
    end
    // blend only changes with the colors, so compute it once at write time
    blend_d = grsr_pkg::blend_color(fg_d, bg_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= grsr_pkg::FG_RESET;
      bg_q     <= grsr_pkg::BG_RESET;
      blend_q  <= grsr_pkg::BLEND_RESET;
      smooth_q <= 1'b1;
      bgon_q   <= 1'b1;
    end else begin
      fg_q     <= fg_d;
      bg_q     <= bg_d;
      blend_q  <= blend_d;
      smooth_q <= smooth_d;
      bgon_q   <= bgon_d;
    end
  end

  assign cfg_o.fg        = fg_q;
  assign cfg_o.bg        = bg_q;
  assign cfg_o.blend     = blend_q;
  assign cfg_o.smooth_on = smooth_q;
  assign cfg_o.bg_on     = bgon_q;

endmodule

// File: sv/grsr_lane.sv
// ----------------------------------------------------------------------------
// grsr_lane
// One pixel column: smoothing decision and color select.
// ----------------------------------------------------------------------------
module grsr_lane (
  input  grsr_pkg::cfg_t                cfg_i,
  input  logic                          cur_i,
  input  logic                          left_i,
  input  logic                          right_i,
  input  logic                          above_i,
  input  logic                          below_i,
  output logic [grsr_pkg::COLOR_W-1:0]  color_o,
  output logic                          wr_o
);

  logic marked;

  // unset pixel with a set side neighbour and a set pixel above or below
  assign marked = cfg_i.smooth_on & ~cur_i & (left_i | right_i) & (above_i | below_i);

  always_comb begin
    color_o = '0;
    wr_o    = 1'b0;
    if (cur_i) begin
      color_o = cfg_i.fg;
      wr_o    = 1'b1;
    end else if (marked) begin
      color_o = cfg_i.blend;
      wr_o    = 1'b1;
    end else if (cfg_i.bg_on) begin
      color_o = cfg_i.bg;
      wr_o    = 1'b1;
    end
  end

endmodule

// File: sv/grsr_row.sv
// ----------------------------------------------------------------------------
// grsr_row
// Seven column lanes side by side, merged into one row result.
// ----------------------------------------------------------------------------
module grsr_row (
  input  grsr_pkg::cfg_t                cfg_i,
  input  logic [grsr_pkg::ROW_W-1:0]    above_i,
  input  logic [grsr_pkg::ROW_W-1:0]    cur_i,
  input  logic [grsr_pkg::ROW_W-1:0]    below_i,
  input  logic                          done_last_i,
  output grsr_pkg::result_t             res_o
);

  for (genvar c = 0; c < grsr_pkg::ROW_W; c++) begin : g_lane
    localparam int B = grsr_pkg::ROW_W - 1 - c;
    logic left;
    logic right;

    // neighbours beyond the row edges count as unset
    if (B < grsr_pkg::ROW_W - 1) begin : g_left
      assign left = cur_i[B+1];
    end else begin : g_left_edge
      assign left = 1'b0;
    end
    if (B > 0) begin : g_right
      assign right = cur_i[B-1];
    end else begin : g_right_edge
      assign right = 1'b0;
    end

    grsr_lane u_lane (
      .cfg_i   (cfg_i),
      .cur_i   (cur_i[B]),
      .left_i  (left),
      .right_i (right),
      .above_i (above_i[B]),
      .below_i (below_i[B]),
      .color_o (res_o.pix[c]),
      .wr_o    (res_o.mask[B])
    );
  end

  assign res_o.done_last = done_last_i;

endmodule

// File: sv/grsr_outq.sv
// ----------------------------------------------------------------------------
// grsr_outq
// Three-entry result queue: two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module grsr_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_a_i,
  input  grsr_pkg::result_t  res_a_i,
  input  logic               push_b_i,
  input  grsr_pkg::result_t  res_b_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               valid_o,
  output grsr_pkg::result_t  head_o
);

  grsr_pkg::result_t                 ent_q [grsr_pkg::QDEPTH];
  grsr_pkg::result_t                 ent_d [grsr_pkg::QDEPTH];
  logic [grsr_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic [grsr_pkg::QCNT_W-1:0]       cnt_pop;
  logic [grsr_pkg::QCNT_W-1:0]       slot_b;

  assign cnt_pop = cnt_q - grsr_pkg::QCNT_W'(pop_i);
  assign slot_b  = cnt_pop + grsr_pkg::QCNT_W'(push_a_i);
  assign cnt_d   = slot_b + grsr_pkg::QCNT_W'(push_b_i);

  always_comb begin
    for (int i = 0; i < grsr_pkg::QDEPTH; i++) begin
      // shift toward the head on pop
      if (pop_i && i < grsr_pkg::QDEPTH - 1) begin
        ent_d[i] = ent_q[i+1];
      end else begin
        ent_d[i] = ent_q[i];
      end
      if (push_a_i && cnt_pop == grsr_pkg::QCNT_W'(i)) begin
        ent_d[i] = res_a_i;
      end
      if (push_b_i && slot_b == grsr_pkg::QCNT_W'(i)) begin
        ent_d[i] = res_b_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // room for two results must remain before taking another item
  assign full_o  = cnt_q >= grsr_pkg::QCNT_W'(2);
  assign valid_o = cnt_q != '0;
  assign head_o  = ent_q[0];

endmodule

// File: sv/glyph_row_smoothing_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_row_smoothing_rasterizer
// Colors glyph rows with diagonal edge smoothing, one row per unstalled cycle.
// ----------------------------------------------------------------------------
// One row item is taken per cycle while the result queue is not full. A row's
// result is pushed to the queue when the row below it is accepted; the final
// row of a glyph is colored at once, so that item yields two results (held
// row, then final row) and a lone final row yields one. Results pass through
// a three-entry queue that sends one per cycle unless the output stalls; the
// input stalls while two or more results wait. The seven columns are colored
// by seven lanes in parallel in each of the two row blocks; the blend color
// is computed when a color register is written.
module glyph_row_smoothing_rasterizer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [grsr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [grsr_pkg::COLOR_W-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [grsr_pkg::ROW_W-1:0]           row_bits_i,
  input  logic                                 last_row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [grsr_pkg::COLOR_W-1:0]         pix0_color_o,
  output logic [grsr_pkg::COLOR_W-1:0]         pix1_color_o,
  output logic [grsr_pkg::COLOR_W-1:0]         pix2_color_o,
  output logic [grsr_pkg::COLOR_W-1:0]         pix3_color_o,
  output logic [grsr_pkg::COLOR_W-1:0]         pix4_color_o,
  output logic [grsr_pkg::COLOR_W-1:0]         pix5_color_o,
  output logic [grsr_pkg::COLOR_W-1:0]         pix6_color_o,
  output logic [grsr_pkg::ROW_W-1:0]           write_mask_o,
  output logic                                 row_done_last_o
);

  grsr_pkg::cfg_t              cfg;
  grsr_pkg::result_t           res_a;
  grsr_pkg::result_t           res_b;
  grsr_pkg::result_t           head;
  logic                        q_full;
  logic                        in_acc;
  logic                        pop;
  logic [grsr_pkg::ROW_W-1:0]  row_above_q, row_above_d;
  logic [grsr_pkg::ROW_W-1:0]  row_held_q, row_held_d;
  logic                        pending_q, pending_d;
  logic [grsr_pkg::ROW_W-1:0]  above_new;

  grsr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_stall_o = q_full;
  assign in_acc     = in_valid_i & ~q_full;
  assign pop        = out_valid_o & ~out_stall_i;
  assign above_new  = pending_q ? row_held_q : '0;

  // held row, now that the row below it has arrived
  grsr_row u_row_held (
    .cfg_i       (cfg),
    .above_i     (row_above_q),
    .cur_i       (row_held_q),
    .below_i     (row_bits_i),
    .done_last_i (1'b0),
    .res_o       (res_a)
  );

  // final row, with an unset row below
  grsr_row u_row_last (
    .cfg_i       (cfg),
    .above_i     (above_new),
    .cur_i       (row_bits_i),
    .below_i     ('0),
    .done_last_i (1'b1),
    .res_o       (res_b)
  );

  always_comb begin
    row_above_d = row_above_q;
    row_held_d  = row_held_q;
    pending_d   = pending_q;
    if (in_acc) begin
      if (last_row_i) begin
        // start the next glyph clean
        row_above_d = '0;
        row_held_d  = '0;
        pending_d   = 1'b0;
      end else begin
        row_above_d = above_new;
        row_held_d  = row_bits_i;
        pending_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_above_q <= '0;
      row_held_q  <= '0;
      pending_q   <= 1'b0;
    end else begin
      row_above_q <= row_above_d;
      row_held_q  <= row_held_d;
      pending_q   <= pending_d;
    end
  end

  grsr_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (in_acc & pending_q),
    .res_a_i  (res_a),
    .push_b_i (in_acc & last_row_i),
    .res_b_i  (res_b),
    .pop_i    (pop),
    .full_o   (q_full),
    .valid_o  (out_valid_o),
    .head_o   (head)
  );

  assign pix0_color_o    = head.pix[0];
  assign pix1_color_o    = head.pix[1];
  assign pix2_color_o    = head.pix[2];
  assign pix3_color_o    = head.pix[3];
  assign pix4_color_o    = head.pix[4];
  assign pix5_color_o    = head.pix[5];
  assign pix6_color_o    = head.pix[6];
  assign write_mask_o    = head.mask;
  assign row_done_last_o = head.done_last;

endmodule
